// ----- hdl/dss_pkg.sv -----
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the disk seek scheduler.
// ---------------------------------------------------------------------------
package dss_pkg;

    localparam int CylW = 8;
    localparam int TravW = 16;

    // register map, index of each register (byte address is 4 * index)
    localparam logic [1:0] REG_ALGORITHM = 2'd0;
    localparam logic [1:0] REG_SWEEP_UP = 2'd1;
    localparam logic [1:0] REG_START_HEAD = 2'd2;
    localparam logic [1:0] REG_MAX_CYL = 2'd3;

    localparam logic [2:0] ALG_FCFS = 3'd0;
    localparam logic [2:0] ALG_SSTF = 3'd1;
    localparam logic [2:0] ALG_SCAN = 3'd2;
    localparam logic [2:0] ALG_CSCAN = 3'd3;
    localparam logic [2:0] ALG_CLOOK = 3'd4;
    localparam logic [2:0] ALG_SWEEP = 3'd5;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_SCAN,
        S_WAIT,
        S_PICK,
        S_MID1,
        S_MID2,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FILT_ANY,
        FILT_GE,
        FILT_LT
    } filt_t;

    typedef enum logic [1:0] {
        KEY_INDEX,
        KEY_DIST,
        KEY_VAL,
        KEY_VALINV
    } key_t;

    typedef struct packed {
        filt_t filt;
        key_t  key;
        logic  tie_later;
    } sel_cfg_t;

    function automatic logic [CylW-1:0] abs_diff(input logic [CylW-1:0] a,
                                                 input logic [CylW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- hdl/dss_ram.sv -----
// ---------------------------------------------------------------------------
// dss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/dss_select.sv -----
// ---------------------------------------------------------------------------
// dss_select
// Shared compare unit: walks the stored requests one per cycle and keeps
// the best unserved candidate under the current ordering key.
// ---------------------------------------------------------------------------
module dss_select #(
    parameter int AW = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      entry_valid,
    input  dss_pkg::sel_cfg_t         cfg,
    input  logic [dss_pkg::CylW-1:0]  head,
    input  logic [dss_pkg::CylW-1:0]  head0,
    input  logic [dss_pkg::CylW-1:0]  entry_val,
    input  logic [AW-1:0]             entry_idx,
    input  logic                      entry_marked,
    output logic                      found,
    output logic [AW-1:0]             best_idx,
    output logic [dss_pkg::CylW-1:0]  best_val
);
    import dss_pkg::*;

    logic            found_reg, found_next;
    logic [CylW-1:0] best_key_reg, best_key_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic [CylW-1:0] best_val_reg, best_val_next;
    logic [CylW-1:0] key;
    logic            in_range;
    logic            better;

    always_comb
    begin
        case (cfg.key)
            KEY_DIST:   key = abs_diff(entry_val, head);
            KEY_VAL:    key = entry_val;
            KEY_VALINV: key = ~entry_val;
            default:    key = '0;
        endcase
        case (cfg.filt)
            FILT_GE: in_range = (entry_val >= head0);
            FILT_LT: in_range = (entry_val < head0);
            default: in_range = 1'b1;
        endcase
        better = !found_reg || (key < best_key_reg)
                 || (cfg.tie_later && (key == best_key_reg));
    end

    always_comb
    begin
        found_next = found_reg;
        best_key_next = best_key_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (entry_valid && !entry_marked && in_range && better)
        begin
            found_next = 1'b1;
            best_key_next = key;
            best_idx_next = entry_idx;
            best_val_next = entry_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
    end

    assign found = found_reg;
    assign best_idx = best_idx_reg;
    assign best_val = best_val_reg;

endmodule

// ----- hdl/disk_seek_scheduler_core.sv -----
// Disk seek scheduler. Requests are loaded one word per cycle into a request
// RAM; the word flagged last_request closes the batch and starts scheduling,
// during which in_ready stays low. Every stop is found by one pass of a single
// shared compare unit over the stored batch, and a stop can be held while the
// result side stalls. One more empty pass closes the batch; the scan family
// spends another pass where it turns, SCAN adding an end-of-disk move (S_MID1)
// and C-SCAN that move plus the return jump (S_MID1, S_MID2). The output word
// register can hold the final stop while a new batch loads.
// ---------------------------------------------------------------------------
// disk_seek_scheduler_core
// Top level: APB registers, request RAM, sequencer and result register.
// ---------------------------------------------------------------------------
module disk_seek_scheduler_core #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [dss_pkg::CylW-1:0]  request_cylinder,
    input  logic                      last_request,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [dss_pkg::CylW-1:0]  served_cylinder,
    output logic [dss_pkg::TravW-1:0] travel_so_far,
    output logic                      last_of_run
);
    import dss_pkg::*;

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);

    // configuration
    logic [2:0]      algorithm_reg;
    logic            sweep_up_reg;
    logic [CylW-1:0] start_head_reg;
    logic [CylW-1:0] max_cyl_reg;

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [CylW-1:0]         head_reg, head_next;
    logic [CylW-1:0]         head0_reg, head0_next;
    logic [TravW-1:0]        travel_reg, travel_next;
    logic                    phase_reg, phase_next;
    logic                    h0done_reg, h0done_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [CylW-1:0]         pend_cyl_reg, pend_cyl_next;
    logic [TravW-1:0]        pend_trav_reg, pend_trav_next;
    logic [MAX_REQUESTS-1:0] marks_reg, marks_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CylW-1:0]         out_cyl_reg, out_cyl_next;
    logic [TravW-1:0]        out_trav_reg, out_trav_next;
    logic                    out_last_reg, out_last_next;
    logic                    rd_v_reg;
    logic [AW-1:0]           rd_idx_reg;

    logic            in_acc;
    logic            cfg_wr;
    logic [CylW-1:0] req_clamped;
    logic [CylW-1:0] ram_rdata;
    logic            ram_we;
    logic            is_sweep, is_sstf, is_scanfam, is_cscan, is_scan;
    sel_cfg_t        sel_cfg;
    logic            sel_clear;
    logic            found;
    logic [AW-1:0]   best_idx;
    logic [CylW-1:0] best_val;
    logic            out_free;
    logic            emit_cond, use_h0;
    logic [CylW-1:0] stop_cyl, end_cyl;
    logic [TravW-1:0] stop_trav;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign in_ready = (state_reg == S_LOAD);
    assign in_acc = in_valid && in_ready;
    assign req_clamped = (request_cylinder > max_cyl_reg) ? max_cyl_reg : request_cylinder;
    assign ram_we = in_acc && (count_reg < CW'(MAX_REQUESTS));

    always_comb
    begin
        case (paddr[3:2])
            REG_ALGORITHM:  prdata = {29'd0, algorithm_reg};
            REG_SWEEP_UP:   prdata = {31'd0, sweep_up_reg};
            REG_START_HEAD: prdata = {24'd0, start_head_reg};
            REG_MAX_CYL:    prdata = {24'd0, max_cyl_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg <= ALG_FCFS;
            sweep_up_reg <= 1'b1;
            start_head_reg <= '0;
            max_cyl_reg <= 8'd199;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ALGORITHM:  algorithm_reg <= pwdata[2:0];
                REG_SWEEP_UP:   sweep_up_reg <= pwdata[0];
                REG_START_HEAD: start_head_reg <= pwdata[7:0];
                REG_MAX_CYL:    max_cyl_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    dss_ram #(
        .WIDTH(CylW),
        .DEPTH(MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (req_clamped),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // mode decode; codes 6 and 7 fall back to fcfs
    assign is_sweep = (algorithm_reg == ALG_SWEEP);
    assign is_sstf = (algorithm_reg == ALG_SSTF);
    assign is_scan = (algorithm_reg == ALG_SCAN);
    assign is_cscan = (algorithm_reg == ALG_CSCAN);
    assign is_scanfam = (algorithm_reg inside {ALG_SCAN, ALG_CSCAN, ALG_CLOOK});

    always_comb
    begin
        sel_cfg = '{filt: FILT_ANY, key: KEY_INDEX, tie_later: 1'b0};
        if (is_sstf)
        begin
            sel_cfg = '{filt: FILT_ANY, key: KEY_DIST, tie_later: 1'b1};
        end
        else if (is_sweep)
        begin
            sel_cfg = '{filt: FILT_ANY, key: KEY_VAL, tie_later: 1'b0};
        end
        else if (is_scanfam)
        begin
            if (!phase_reg)
            begin
                sel_cfg = sweep_up_reg
                    ? '{filt: FILT_GE, key: KEY_VAL, tie_later: 1'b0}
                    : '{filt: FILT_LT, key: KEY_VALINV, tie_later: 1'b0};
            end
            else if (sweep_up_reg)
            begin
                sel_cfg = is_scan
                    ? '{filt: FILT_LT, key: KEY_VALINV, tie_later: 1'b0}
                    : '{filt: FILT_LT, key: KEY_VAL, tie_later: 1'b0};
            end
            else
            begin
                sel_cfg = is_scan
                    ? '{filt: FILT_GE, key: KEY_VAL, tie_later: 1'b0}
                    : '{filt: FILT_GE, key: KEY_VALINV, tie_later: 1'b0};
            end
        end
    end

    assign sel_clear = (state_reg == S_SCAN) && (idx_reg == '0);

    dss_select #(
        .AW(AW)
    ) u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (sel_clear),
        .entry_valid  (rd_v_reg),
        .cfg          (sel_cfg),
        .head         (head_reg),
        .head0        (head0_reg),
        .entry_val    (ram_rdata),
        .entry_idx    (rd_idx_reg),
        .entry_marked (marks_reg[rd_idx_reg]),
        .found        (found),
        .best_idx     (best_idx),
        .best_val     (best_val)
    );

    assign out_free = !out_valid_reg || out_ready;
    // the sweep mode slips the start head in as an extra stop
    assign use_h0 = is_sweep && !h0done_reg && (!found || (head0_reg <= best_val));
    assign emit_cond = found || (is_sweep && !h0done_reg);
    assign stop_cyl = use_h0 ? head0_reg : best_val;
    assign stop_trav = travel_reg + TravW'(abs_diff(stop_cyl, head_reg));
    assign end_cyl = sweep_up_reg ? max_cyl_reg : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc && last_request)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (CW'(idx_reg) == count_reg - CW'(1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (emit_cond)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (is_scanfam && !phase_reg)
                begin
                    state_next = (is_scan || is_cscan) ? S_MID1 : S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MID1:
            begin
                state_next = is_cscan ? S_MID2 : S_SCAN;
            end
            S_MID2:
            begin
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        head_next = head_reg;
        head0_next = head0_reg;
        travel_next = travel_reg;
        phase_next = phase_reg;
        h0done_next = h0done_reg;
        pend_valid_next = pend_valid_reg;
        pend_cyl_next = pend_cyl_reg;
        pend_trav_next = pend_trav_reg;
        marks_next = marks_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cyl_next = out_cyl_reg;
        out_trav_next = out_trav_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (ram_we)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_INIT:
            begin
                head0_next = (start_head_reg > max_cyl_reg) ? max_cyl_reg : start_head_reg;
                travel_next = '0;
                phase_next = 1'b0;
                h0done_next = 1'b0;
                idx_next = '0;
                marks_next = '0;
                pend_valid_next = is_sweep;
                pend_cyl_next = '0;
                pend_trav_next = '0;
                head_next = is_sweep ? '0
                    : ((start_head_reg > max_cyl_reg) ? max_cyl_reg : start_head_reg);
            end
            S_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
            end
            S_PICK:
            begin
                idx_next = '0;
                if (emit_cond && (!pend_valid_reg || out_free))
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_cyl_next = pend_cyl_reg;
                        out_trav_next = pend_trav_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_cyl_next = stop_cyl;
                    pend_trav_next = stop_trav;
                    travel_next = stop_trav;
                    head_next = stop_cyl;
                    if (use_h0)
                    begin
                        h0done_next = 1'b1;
                    end
                    else
                    begin
                        marks_next[best_idx] = 1'b1;
                    end
                end
                else if (!emit_cond && is_scanfam && !phase_reg && !(is_scan || is_cscan))
                begin
                    phase_next = 1'b1;
                end
            end
            S_MID1:
            begin
                // run out to the end of the disk
                travel_next = travel_reg + TravW'(abs_diff(end_cyl, head_reg));
                head_next = end_cyl;
                if (!is_cscan)
                begin
                    phase_next = 1'b1;
                end
            end
            S_MID2:
            begin
                // c-scan return jump
                travel_next = travel_reg + TravW'(max_cyl_reg);
                head_next = sweep_up_reg ? '0 : max_cyl_reg;
                phase_next = 1'b1;
            end
            S_DONE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_cyl_next = pend_cyl_reg;
                        out_trav_next = travel_reg;
                        out_last_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next = '0;
                    marks_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            idx_reg <= '0;
            head_reg <= '0;
            travel_reg <= '0;
            phase_reg <= 1'b0;
            h0done_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            marks_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            head_reg <= head_next;
            travel_reg <= travel_next;
            phase_reg <= phase_next;
            h0done_reg <= h0done_next;
            pend_valid_reg <= pend_valid_next;
            marks_reg <= marks_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg <= (state_reg == S_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        head0_reg <= head0_next;
        pend_cyl_reg <= pend_cyl_next;
        pend_trav_reg <= pend_trav_next;
        out_cyl_reg <= out_cyl_next;
        out_trav_reg <= out_trav_next;
        out_last_reg <= out_last_next;
        rd_idx_reg <= idx_reg;
    end

    assign out_valid = out_valid_reg;
    assign served_cylinder = out_cyl_reg;
    assign travel_so_far = out_trav_reg;
    assign last_of_run = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REQUESTS))
        else $error("request count beyond store depth");

    a_no_pending_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !pend_valid_reg)
        else $error("stop left pending after batch end");

    a_pick_unserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && found) |-> !marks_reg[best_idx])
        else $error("selected request already served");

    a_travel_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |=> (travel_reg >= $past(travel_reg)))
        else $error("head travel decreased within a batch");

endmodule
